FILE: hw/rtl/rlp_pkg.sv
// Shared types, widths, operation codes and constant tables for the region lightness block.
// Used by rlp_ctrl, rlp_dpath and region_lightness_from_pixels_core; depends on nothing.
package rlp_pkg;

  // Store and counter widths.
  localparam int unsigned MAX_POINTS = 4096;
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int CW    = AW + 1;
  localparam int TW    = 11;
  localparam int ACCW  = 19;
  localparam int DVW   = 30;
  localparam int DSW   = 18;
  localparam int RMW   = DSW + 1;
  localparam int DCW   = 5;
  localparam int MW    = 31;
  localparam int PW    = 2 * MW;
  localparam int YW    = 17;
  localparam int YAW   = 33;
  localparam int LW    = 15;
  localparam int LINW  = 17;

  // Fixed-point constants.
  localparam logic [MW-1:0]  Q30_ONE     = MW'(1) << 30;
  localparam logic [YW-1:0]  Y_LIN_LIMIT = YW'(581);
  localparam logic [MW-1:0]  SMALL_GAIN  = MW'(903292);
  localparam logic [MW-1:0]  SMALL_BIAS  = MW'(128000);
  localparam logic [MW-1:0]  CUBE_GAIN   = MW'(29696);
  localparam logic [LW-1:0]  L_OFFSET    = LW'(4096);

  // The linear L* branch divides by 256000 = 2^11 * 125. The numerator is first
  // shifted down by 11, then divided by 125 through a multiply by ceil(2^25 / 125)
  // and a shift by 25, which is exact for every numerator below Y = 581.
  localparam int             SMALL_PRE   = 11;
  localparam int             SMALL_SHIFT = 25;
  localparam logic [MW-1:0]  SMALL_RCP   = MW'(268436);

  // Datapath operation codes.
  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_START     = 5'd1;
  localparam logic [4:0] OP_READ      = 5'd2;
  localparam logic [4:0] OP_DIV_CH    = 5'd3;
  localparam logic [4:0] OP_SMALL_RCP = 5'd4;
  localparam logic [4:0] OP_DIV_STEP  = 5'd5;
  localparam logic [4:0] OP_LIN_MUL   = 5'd6;
  localparam logic [4:0] OP_Y_ACC     = 5'd7;
  localparam logic [4:0] OP_Y_FIN     = 5'd8;
  localparam logic [4:0] OP_SMALL_MUL = 5'd9;
  localparam logic [4:0] OP_R_INIT    = 5'd10;
  localparam logic [4:0] OP_R_MID     = 5'd11;
  localparam logic [4:0] OP_R_SQ      = 5'd12;
  localparam logic [4:0] OP_R_CUBE    = 5'd13;
  localparam logic [4:0] OP_R_CMP     = 5'd14;
  localparam logic [4:0] OP_R_FMUL    = 5'd15;
  localparam logic [4:0] OP_L_ROOT    = 5'd16;
  localparam logic [4:0] OP_L_QUO     = 5'd17;
  localparam logic [4:0] OP_SET_ERR   = 5'd18;
  localparam logic [4:0] OP_PUBLISH   = 5'd19;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic       load_px;
    logic [4:0] op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic run_empty;
    logic rd_idle;
    logic part_last;
    logic y_small;
    logic root_done;
    logic div_done;
  } sts_t;

  typedef logic [LINW-1:0] lin_tab_t [256];

  // Truncating Q30 fifth power.
  function automatic longint unsigned pow5_q30(longint unsigned x);
    longint unsigned r;
    r = 64'd1 << 30;
    for (int i = 0; i < 5; i++) begin
      r = (r * x) >> 30;
    end
    return r;
  endfunction

  // Largest Q30 value whose fifth power does not exceed the target.
  function automatic longint unsigned root5_q30(longint unsigned tgt);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 64'd0;
    hi = 64'd1 << 30;
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (pow5_q30(mid) <= tgt) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return lo;
  endfunction

  // sRGB curve to Q0.16 for one 8-bit channel value.
  function automatic longint unsigned srgb_lin(longint unsigned c);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned s;
    longint unsigned lin;
    if (c <= 64'd10) begin
      return (c * 64'd13107200 + 64'd329460) / 64'd658920;
    end
    t   = (((64'd1000 * c + 64'd14025) << 30) * 64'd2 + 64'd269025) / 64'd538050;
    t2  = (t * t + (64'd1 << 29)) >> 30;
    s   = root5_q30(t2);
    lin = (t2 * s) >> 30;
    return (lin + (64'd1 << 13)) >> 14;
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = LINW'(srgb_lin(64'(i)));
    end
    return tab;
  endfunction

  // Linearization table, worked out at elaboration.
  localparam lin_tab_t LIN_TABLE = build_lin_tab();

  // Luminance weight of each channel, Q0.16.
  function automatic logic [MW-1:0] lum_weight(logic [1:0] part);
    logic [MW-1:0] w;
    case (part)
      2'd0:    w = MW'(13938);
      2'd1:    w = MW'(46868);
      default: w = MW'(4730);
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/region_lightness_from_pixels_core.sv
// Region lightness core: takes a run of 8-bit pixel values and returns CIE L* times 256.
// After the last pixel, the block sums and divides the three channels (n kept pixels,
// 30-step divider per channel), then takes either the linear branch or the cube-root
// search (up to 31 steps).
// Throughput: one pixel per cycle while loading; the input stalls from the last pixel
// until the result is handed over. Synchronous active-low reset clears counters and
// control; the pixel store is not cleared. Depends on rlp_pkg, rlp_ctrl and rlp_dpath.
module region_lightness_from_pixels_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_pixel,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [rlp_pkg::LW-1:0] out_lightness,
  output logic                   out_error
);
  import rlp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each run.
  rlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  rlp_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_pixel      (in_pixel),
    .out_lightness (out_lightness),
    .out_error     (out_error)
  );

endmodule

FILE: hw/rtl/rlp_ctrl.sv
// Controller state machine of the region lightness block.
// Depends on rlp_pkg; drives the datapath through cmd_t and reads sts_t.
module rlp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  rlp_pkg::sts_t sts,
  output rlp_pkg::cmd_t cmd
);
  import rlp_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHECK  = 5'd1;
  localparam logic [4:0] S_RD     = 5'd2;
  localparam logic [4:0] S_DIVL   = 5'd3;
  localparam logic [4:0] S_DIV    = 5'd4;
  localparam logic [4:0] S_LINMUL = 5'd5;
  localparam logic [4:0] S_LINACC = 5'd6;
  localparam logic [4:0] S_YFIN   = 5'd7;
  localparam logic [4:0] S_BRANCH = 5'd8;
  localparam logic [4:0] S_RCP    = 5'd9;
  localparam logic [4:0] S_LSET   = 5'd10;
  localparam logic [4:0] S_R0     = 5'd11;
  localparam logic [4:0] S_R1     = 5'd12;
  localparam logic [4:0] S_R2     = 5'd13;
  localparam logic [4:0] S_R3     = 5'd14;
  localparam logic [4:0] S_RFIN   = 5'd15;
  localparam logic [4:0] S_RL     = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.load_px   = 1'b0;
    cmd.op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.load_px = 1'b1;
          if (in_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.run_empty) begin
          cmd.op    = OP_SET_ERR;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_START;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (sts.rd_idle) begin
          state_nxt = S_DIVL;
        end else begin
          cmd.op = OP_READ;
        end
      end
      S_DIVL: begin
        cmd.op    = OP_DIV_CH;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_LINMUL;
        end else begin
          cmd.op = OP_DIV_STEP;
        end
      end
      S_LINMUL: begin
        cmd.op    = OP_LIN_MUL;
        state_nxt = S_LINACC;
      end
      S_LINACC: begin
        cmd.op    = OP_Y_ACC;
        state_nxt = sts.part_last ? S_YFIN : S_RD;
      end
      S_YFIN: begin
        cmd.op    = OP_Y_FIN;
        state_nxt = S_BRANCH;
      end
      S_BRANCH: begin
        if (sts.y_small) begin
          cmd.op    = OP_SMALL_MUL;
          state_nxt = S_RCP;
        end else begin
          cmd.op    = OP_R_INIT;
          state_nxt = S_R0;
        end
      end
      S_RCP: begin
        cmd.op    = OP_SMALL_RCP;
        state_nxt = S_LSET;
      end
      S_LSET: begin
        cmd.op    = OP_L_QUO;
        state_nxt = S_OUT;
      end
      S_R0: begin
        if (sts.root_done) begin
          state_nxt = S_RFIN;
        end else begin
          cmd.op    = OP_R_MID;
          state_nxt = S_R1;
        end
      end
      S_R1: begin
        cmd.op    = OP_R_SQ;
        state_nxt = S_R2;
      end
      S_R2: begin
        cmd.op    = OP_R_CUBE;
        state_nxt = S_R3;
      end
      S_R3: begin
        cmd.op    = OP_R_CMP;
        state_nxt = S_R0;
      end
      S_RFIN: begin
        cmd.op    = OP_R_FMUL;
        state_nxt = S_RL;
      end
      S_RL: begin
        cmd.op    = OP_L_ROOT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/rlp_dpath.sv
// Datapath of the region lightness block: pixel store, run counters, divider,
// shared multiplier, cube-root search and result registers. Depends on rlp_pkg.
module rlp_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rlp_pkg::cmd_t        cmd,
  output rlp_pkg::sts_t        sts,
  input  logic [7:0]           in_pixel,
  output logic [rlp_pkg::LW-1:0] out_lightness,
  output logic                 out_error
);
  import rlp_pkg::*;

  logic [7:0]      mem [MAX_POINTS];

  logic [CW-1:0]   count_r;
  logic [1:0]      mod3_r;
  logic [TW-1:0]   third_r;
  logic [AW-1:0]   addr_r;
  logic [TW-1:0]   j_r;
  logic            pend_r;
  logic [7:0]      rd_data_r;
  logic [ACCW-1:0] acc_r;
  logic [1:0]      part_r;
  logic [RMW-1:0]  rem_r;
  logic [DVW-1:0]  quo_r;
  logic [DSW-1:0]  dsr_r;
  logic [DCW-1:0]  dcnt_r;
  logic [PW-1:0]   prod_r;
  logic [YAW-1:0]  yacc_r;
  logic [YW-1:0]   y_r;
  logic [MW-1:0]   lo_r, hi_r, mid_r;
  logic [LW-1:0]   l_r;
  logic            err_r;
  logic [LW-1:0]   out_l_r;
  logic            out_err_r;

  logic            rd_go;
  logic [RMW-1:0]  shr;
  logic [RMW-1:0]  sub;
  logic [7:0]      ch;
  logic [MW-1:0]   mul_a, mul_b;
  logic [CW-1:0]   n_val;
  logic [LW-1:0]   froot;
  logic [MW-1:0]   small_num;

  assign rd_go = (cmd.op == OP_READ) && (j_r != third_r);
  assign n_val = CW'({third_r, 1'b0}) + CW'(third_r);

  // Status toward the controller.
  assign sts.run_empty = (third_r == '0);
  assign sts.rd_idle   = (j_r == third_r) && !pend_r;
  assign sts.part_last = (part_r == 2'd2);
  assign sts.y_small   = (y_r < Y_LIN_LIMIT);
  assign sts.root_done = (lo_r == hi_r);
  assign sts.div_done  = (dcnt_r == DCW'(DVW));

  // Restoring divider step.
  assign shr = {rem_r[RMW-2:0], quo_r[DVW-1]};
  assign sub = shr - RMW'(dsr_r);

  // Rounded numerator of the linear L* branch.
  assign small_num = prod_r[MW-1:0] + SMALL_BIAS;

  // Channel value: three times the quotient, saturated.
  always_comb begin
    if (quo_r > DVW'(85)) begin
      ch = 8'd255;
    end else begin
      ch = {quo_r[6:0], 1'b0} + quo_r[7:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_LIN_MUL: begin
        mul_a = lum_weight(part_r);
        mul_b = MW'(LIN_TABLE[ch]);
      end
      OP_SMALL_MUL: begin
        mul_a = MW'(y_r);
        mul_b = SMALL_GAIN;
      end
      OP_SMALL_RCP: begin
        mul_a = small_num >> SMALL_PRE;
        mul_b = SMALL_RCP;
      end
      OP_R_SQ: begin
        mul_a = mid_r;
        mul_b = mid_r;
      end
      OP_R_CUBE: begin
        mul_a = prod_r[60:30];
        mul_b = mid_r;
      end
      OP_R_FMUL: begin
        mul_a = CUBE_GAIN;
        mul_b = lo_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounded cube-root branch result before the offset.
  assign froot = LW'((prod_r + (PW'(1) << 29)) >> 30);

  // Pixel store: written while loading, read while summing.
  always_ff @(posedge clk) begin
    if (cmd.load_px && (count_r < CW'(MAX_POINTS))) begin
      mem[count_r[AW-1:0]] <= in_pixel;
    end
    if (rd_go) begin
      rd_data_r <= mem[addr_r];
    end
  end

  // Run counters and read control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mod3_r  <= '0;
      third_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.load_px && (count_r < CW'(MAX_POINTS))) begin
        count_r <= count_r + CW'(1);
        if (mod3_r == 2'd2) begin
          mod3_r  <= 2'd0;
          third_r <= third_r + TW'(1);
        end else begin
          mod3_r <= mod3_r + 2'd1;
        end
      end else if ((cmd.op == OP_PUBLISH) || (cmd.op == OP_SET_ERR)) begin
        count_r <= '0;
        mod3_r  <= '0;
        third_r <= '0;
      end
      if (cmd.op == OP_START) begin
        pend_r <= 1'b0;
      end else if (cmd.op == OP_READ) begin
        pend_r <= rd_go;
      end
    end
  end

  // Arithmetic registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        addr_r <= '0;
        j_r    <= '0;
        acc_r  <= '0;
        part_r <= 2'd0;
        yacc_r <= '0;
        err_r  <= 1'b0;
      end
      OP_READ: begin
        if (rd_go) begin
          addr_r <= addr_r + AW'(1);
          j_r    <= j_r + TW'(1);
        end
        if (pend_r) begin
          acc_r <= acc_r + ACCW'(rd_data_r);
        end
      end
      OP_DIV_CH: begin
        rem_r  <= '0;
        quo_r  <= DVW'(acc_r);
        dsr_r  <= DSW'(n_val);
        dcnt_r <= '0;
      end
      OP_DIV_STEP: begin
        if (shr >= RMW'(dsr_r)) begin
          rem_r <= sub;
          quo_r <= {quo_r[DVW-2:0], 1'b1};
        end else begin
          rem_r <= shr;
          quo_r <= {quo_r[DVW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r + DCW'(1);
      end
      OP_LIN_MUL, OP_SMALL_MUL, OP_SMALL_RCP, OP_R_SQ, OP_R_CUBE, OP_R_FMUL: begin
        prod_r <= mul_a * mul_b;
      end
      OP_Y_ACC: begin
        yacc_r <= yacc_r + YAW'(prod_r);
        part_r <= part_r + 2'd1;
        acc_r  <= '0;
        j_r    <= '0;
      end
      OP_Y_FIN: begin
        y_r <= YW'((yacc_r + YAW'(32768)) >> 16);
      end
      OP_R_INIT: begin
        lo_r <= '0;
        hi_r <= Q30_ONE;
      end
      OP_R_MID: begin
        mid_r <= MW'(({1'b0, lo_r} + {1'b0, hi_r} + (MW + 1)'(1)) >> 1);
      end
      OP_R_CMP: begin
        // Keep mid when its cube stays at or under Y in Q30.
        if (prod_r[PW-1:30] <= {1'b0, y_r, 14'b0}) begin
          lo_r <= mid_r;
        end else begin
          hi_r <= mid_r - MW'(1);
        end
      end
      OP_L_ROOT: begin
        l_r <= (froot < L_OFFSET) ? '0 : froot - L_OFFSET;
      end
      OP_L_QUO: begin
        l_r <= prod_r[SMALL_SHIFT +: LW];
      end
      OP_SET_ERR: begin
        l_r   <= '0;
        err_r <= 1'b1;
      end
      OP_PUBLISH: begin
        out_l_r   <= l_r;
        out_err_r <= err_r;
      end
      default: begin
      end
    endcase
  end

  assign out_lightness = out_l_r;
  assign out_error     = out_err_r;

endmodule

FILE: hw/rtl/rlp_checker.sv
// Port-level checker for the region lightness core, with its bind statement.
// Depends on rlp_pkg and region_lightness_from_pixels_core.
module rlp_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [rlp_pkg::LW-1:0] out_lightness,
  input logic                   out_error
);
  import rlp_pkg::*;

  // No result comes out of reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input side is ready right after reset.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // An error result carries zero lightness.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_lightness == '0)
    else $error("error result with nonzero lightness");

  // Lightness stays within the L* range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_lightness <= LW'(25600))
    else $error("lightness out of range");

  // A stalled result transaction holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_lightness) && $stable(out_error))
    else $error("stalled result changed");

endmodule

bind region_lightness_from_pixels_core rlp_checker u_rlp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_lightness (out_lightness),
  .out_error     (out_error)
);

FILE: verif/tb_top.sv
// Self-checking testbench for region_lightness_from_pixels_core: pixel runs in, CIE L* out.
// Depends on rlp_pkg and the core RTL. An internal lightness predictor checks every result.
`timescale 1ns / 100ps

module tb_top;

  localparam int STORE_DEPTH = 4096;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic [rlp_pkg::LW-1:0] lightness;
    logic                   error;
  } lightness_res_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_pixel;
  logic                   in_last;
  logic                   out_valid;
  logic                   out_stall;
  logic [rlp_pkg::LW-1:0] out_lightness;
  logic                   out_error;

  // Predictor state: a copy of the run store and its fill count.
  logic [7:0]     run_pixels [STORE_DEPTH];
  int unsigned    run_len;
  lightness_res_t lightness_q[$];

  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned pixels_sent;

  region_lightness_from_pixels_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel     (in_pixel),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_lightness(out_lightness),
    .out_error    (out_error)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Floor k-th root in Q30, with each product truncated back to Q30.
  function automatic longint unsigned floor_root_q30(longint unsigned tgt, int k);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned acc;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      acc = 64'd1 << 30;
      for (int i = 0; i < k; i++) begin
        acc = (acc * mid) >> 30;
      end
      if (acc <= tgt) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo;
  endfunction

  // sRGB decoding of one channel to Q0.16.
  function automatic longint unsigned srgb_decode_q16(longint unsigned c);
    longint unsigned base;
    longint unsigned sq;
    longint unsigned r5;
    if (c <= 10) begin
      return (c * 13107200 + 329460) / 658920;
    end
    base = (((1000 * c + 14025) << 31) + 269025) / 538050;
    sq   = (base * base + (64'd1 << 29)) >> 30;
    r5   = floor_root_q30(sq, 5);
    return (((sq * r5) >> 30) + (64'd1 << 13)) >> 14;
  endfunction

  // L* times 256 from Q0.16 luminance.
  function automatic logic [rlp_pkg::LW-1:0] lstar_from_y(longint unsigned y);
    longint signed l;
    longint unsigned f;
    if (y >= 581) begin
      f = floor_root_q30(y << 14, 3);
      l = longint'((29696 * f + (64'd1 << 29)) >> 30) - 4096;
    end else begin
      l = longint'((y * 231242752 + 32768000) / 65536000);
    end
    if (l < 0) l = 0;
    if (l > 32767) l = 32767;
    return rlp_pkg::LW'(l);
  endfunction

  // Updates the predictor with one accepted pixel; closes the run on last.
  task automatic predict_pixel(input logic [7:0] px, input logic lst);
    int unsigned kept;
    int unsigned third;
    longint unsigned sum;
    longint unsigned ch;
    longint unsigned y;
    lightness_res_t res;
    if (run_len < STORE_DEPTH) begin
      run_pixels[run_len] = px;
      run_len++;
    end
    if (lst) begin
      kept = run_len - run_len % 3;
      run_len = 0;
      if (kept < 3) begin
        res.lightness = '0;
        res.error = 1'b1;
      end else begin
        third = kept / 3;
        y = 32768;
        for (int p = 0; p < 3; p++) begin
          sum = 0;
          for (int i = p * third; i < (p + 1) * third; i++) begin
            sum += run_pixels[i];
          end
          ch = (sum / kept) * 3;
          if (ch > 255) ch = 255;
          y += (p == 0 ? 13938 : (p == 1 ? 46868 : 4730)) * srgb_decode_q16(ch);
        end
        res.lightness = lstar_from_y(y >> 16);
        res.error = 1'b0;
      end
      lightness_q = {lightness_q, res};
    end
  endtask

  // Sends one pixel transaction, with random idle cycles before it.
  task automatic send_pixel(input logic [7:0] px, input logic lst);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    in_last  <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(px, lst);
    pixels_sent++;
  endtask

  task automatic send_run(input int len, input int unsigned max_px);
    for (int i = 0; i < len; i++) begin
      send_pixel(8'($urandom_range(max_px)), i == len - 1);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (lightness_q.size() != 0) @(posedge clk);
  endtask

  // Result checker.
  always @(posedge clk) begin
    lightness_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lightness_q.size() == 0) begin
        report_mismatch("unexpected result, lightness", out_lightness, -1);
      end else begin
        want = lightness_q.pop_front();
        if (out_lightness !== want.lightness)
          report_mismatch("lightness", out_lightness, want.lightness);
        if (out_error !== want.error)
          report_mismatch("error", out_error, want.error);
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Short runs: two that end before three pixels are kept, then a five-pixel run.
  task automatic test_too_few();
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_run(5, 255);
  endtask

  // Field extremes, the linear sRGB segment and both L* branches.
  task automatic test_extremes();
    for (int i = 0; i < 3; i++) send_pixel(8'd0, i == 2);
    for (int i = 0; i < 3; i++) send_pixel(8'd255, i == 2);
    for (int i = 0; i < 4; i++) send_pixel(8'd3, i == 3);
    for (int i = 0; i < 6; i++) send_pixel(i < 2 ? 8'd255 : 8'd10, i == 5);
    for (int i = 0; i < 3; i++) send_pixel(8'd12, i == 2);
  endtask

  // Pause until the core has answered everything, then go on.
  task automatic test_drain_pause();
    send_run(7, 255);
    wait_drained();
    send_run(9, 255);
  endtask

  // Random runs, mostly short, under one idling pattern.
  task automatic test_random_runs(input int unsigned idle_pct, input int unsigned st_pct,
                                  input int unsigned budget);
    int unsigned target;
    int len;
    wait_drained();
    send_idle_pct = idle_pct;
    stall_pct = st_pct;
    target = pixels_sent + budget;
    while (pixels_sent < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(120, 20) : $urandom_range(14, 1);
      send_run(len, ($urandom_range(3) == 0) ? 15 : 255);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel = '0;
    in_last = 1'b0;
    out_stall = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    pixels_sent = 0;
    run_len = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_too_few();
    test_extremes();
    test_drain_pause();
    test_random_runs(0, 0, 425);
    test_random_runs(56, 0, 425);
    test_random_runs(0, 56, 425);
    test_random_runs(19, 19, 425);

    wait_drained();
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
